FILE: rtl/core/whb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package whb_pkg;

    localparam logic [1:0] REQ_ADD        = 2'd0;
    localparam logic [1:0] REQ_READ       = 2'd1;
    localparam logic [1:0] REQ_READ_CLEAR = 2'd2;

    localparam logic [2:0] CFG_LOG_MODE      = 3'd0;
    localparam logic [2:0] CFG_WEIGHTED_MODE = 3'd1;
    localparam logic [2:0] CFG_BIN_COUNT     = 3'd2;
    localparam logic [2:0] CFG_RANGE_START   = 3'd3;
    localparam logic [2:0] CFG_BINS_PER_UNIT = 3'd4;

    localparam logic [11:0] BIN_COUNT_RST     = 12'd4095;
    localparam logic [31:0] BINS_PER_UNIT_RST = 32'd65536;

    // Commands from the controller to the datapath, one step per flag.
    typedef struct packed {
        logic clr_en;
        logic load;
        logic lz_en;
        logic key_en;
        logic mul_en;
        logic bin_en;
        logic rd_en;
        logic upd_en;
    } whb_cmd_t;

    typedef struct packed {
        logic clr_last;
    } whb_status_t;

    // Fractional part of log2(1 + j / 2^lbits) in Q0.16, by repeated squaring.
    function automatic logic [15:0] whb_log_entry(input int j, input int lbits);
        logic [63:0] m;
        logic [15:0] r;
        m = (64'd1 << 30) + (64'(j) << (30 - lbits));
        r = '0;
        for (int k = 0; k < 16; k++) begin
            m = (m * m) >> 30;
            r = {r[14:0], 1'b0};
            if (m >= (64'd1 << 31)) begin
                r = r | 16'd1;
                m = m >> 1;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/whb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module whb_ctrl
    import whb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  whb_status_t      status,
    output whb_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_LZ, S_KEY, S_MUL, S_BIN, S_RD, S_UPD
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   upd_go;

    assign upd_go   = (state_reg == S_UPD) && (!out_valid_reg || m_tready);
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        cmd        = '0;
        cmd.clr_en = (state_reg == S_CLEAR);
        cmd.load   = (state_reg == S_IDLE) && s_tvalid;
        cmd.lz_en  = (state_reg == S_LZ);
        cmd.key_en = (state_reg == S_KEY);
        cmd.mul_en = (state_reg == S_MUL);
        cmd.bin_en = (state_reg == S_BIN);
        cmd.rd_en  = (state_reg == S_RD);
        cmd.upd_en = upd_go;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            if (upd_go) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: if (status.clr_last) state_reg <= S_IDLE;
                S_IDLE:  if (s_tvalid) state_reg <= S_LZ;
                S_LZ:    state_reg <= S_KEY;
                S_KEY:   state_reg <= S_MUL;
                S_MUL:   state_reg <= S_BIN;
                S_BIN:   state_reg <= S_RD;
                S_RD:    state_reg <= S_UPD;
                S_UPD:   if (upd_go) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/whb_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module whb_dpath
    import whb_pkg::*;
#(
    parameter int NUM_BINS       = 4096,
    parameter int LOG_TABLE_BITS = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  whb_cmd_t         cmd,
    output whb_status_t      status,
    input  wire logic        cfg_valid,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic [1:0]  in_req,
    input  wire logic [31:0] in_x,
    input  wire logic [31:0] in_w,
    input  wire logic [31:0] in_v,
    input  wire logic [11:0] in_ridx,
    output logic [11:0]      out_bin,
    output logic [63:0]      out_total,
    output logic             out_dropped,
    output logic             out_under,
    output logic             out_sat
);

    localparam int BW   = $clog2(NUM_BINS);
    localparam int TBL  = 1 << LOG_TABLE_BITS;
    localparam int SHW  = 32 + LOG_TABLE_BITS;
    localparam logic [32:0] MAX_BIN = 33'(NUM_BINS - 1);

    logic [15:0] log_tab [TBL];
    for (genvar g = 0; g < TBL; g++) begin : g_tab
        assign log_tab[g] = whb_log_entry(g, LOG_TABLE_BITS);
    end

    // Configuration registers
    logic        log_mode_reg;
    logic        weighted_reg;
    logic [11:0] bin_count_reg;
    logic [31:0] range_start_reg;
    logic [31:0] bpu_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            log_mode_reg    <= 1'b0;
            weighted_reg    <= 1'b0;
            bin_count_reg   <= BIN_COUNT_RST;
            range_start_reg <= '0;
            bpu_reg         <= BINS_PER_UNIT_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_LOG_MODE:      log_mode_reg    <= cfg_data[0];
                CFG_WEIGHTED_MODE: weighted_reg    <= cfg_data[0];
                CFG_BIN_COUNT:     bin_count_reg   <= cfg_data[11:0];
                CFG_RANGE_START:   range_start_reg <= cfg_data;
                CFG_BINS_PER_UNIT: bpu_reg         <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clearing pass counter
    logic [BW-1:0] clr_cnt_reg;
    assign status.clr_last = (clr_cnt_reg == BW'(NUM_BINS - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clr_en) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Request capture
    logic [1:0]  req_reg;
    logic [31:0] x_reg, w_reg, v_reg;
    logic [11:0] ridx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg  <= in_req;
            x_reg    <= in_x;
            w_reg    <= in_w;
            v_reg    <= in_v;
            ridx_reg <= in_ridx;
        end
    end

    // Leading-one position of the sample
    logic [4:0] p_next, p_reg;
    always_comb begin
        p_next = '0;
        for (int i = 0; i < 32; i++) begin
            if (x_reg[i]) p_next = 5'(i);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.lz_en) p_reg <= p_next;
    end

    // Key and distance from the lower edge
    logic [SHW-1:0]            mant_sh;
    logic [LOG_TABLE_BITS-1:0] tab_idx;
    logic signed [16:0]        exp_part;
    logic signed [33:0]        key, d_next, d_reg;
    logic                      xnonpos, under_next, under_reg;

    assign mant_sh  = {x_reg, {LOG_TABLE_BITS{1'b0}}} >> p_reg;
    assign tab_idx  = mant_sh[LOG_TABLE_BITS-1:0];
    assign exp_part = $signed({12'd0, p_reg}) - 17'sd16;
    assign xnonpos  = x_reg[31] || (x_reg == '0);
    assign key      = log_mode_reg ? 34'($signed({exp_part, log_tab[tab_idx]}))
                                   : 34'($signed(x_reg));
    assign d_next   = key - 34'($signed(range_start_reg));
    assign under_next = (log_mode_reg && xnonpos) || (d_next[33] && (bpu_reg != '0));

    always_ff @(posedge aclk) begin
        if (cmd.key_en) begin
            d_reg     <= d_next;
            under_reg <= under_next;
        end
    end

    // Products: bin offset scaling and weighted increment
    logic [63:0] prod_reg, wv_reg;
    logic [31:0] ud;
    assign ud = d_reg[33] ? 32'd0 : d_reg[31:0];

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= 64'(ud) * 64'(bpu_reg);
            wv_reg   <= 64'(w_reg) * 64'(v_reg);
        end
    end

    // Bin selection
    logic [32:0]   bin_next, limit;
    logic          drop_next, drop_reg, ridx_ok;
    logic [BW-1:0] addr_next, addr_reg;
    logic [63:0]   inc_next, inc_reg;

    assign ridx_ok  = (32'(ridx_reg) < 32'(NUM_BINS));
    assign limit    = (33'(bin_count_reg) > MAX_BIN) ? MAX_BIN : 33'(bin_count_reg);
    assign bin_next = 33'(prod_reg[63:32]) + 33'd1;
    assign drop_next = !under_reg && (bin_next > limit);

    always_comb begin
        if (req_reg != REQ_ADD) begin
            addr_next = BW'(ridx_reg);
        end else if (under_reg || drop_next) begin
            addr_next = '0;
        end else begin
            addr_next = BW'(bin_next);
        end
        if (!under_reg && weighted_reg) begin
            inc_next = wv_reg;
        end else begin
            inc_next = {16'd0, v_reg, 16'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.bin_en) begin
            addr_reg <= addr_next;
            drop_reg <= drop_next;
            inc_reg  <= inc_next;
        end
    end

    // Bin store
    logic [63:0]   bin_mem [NUM_BINS];
    logic [63:0]   rdata_reg;
    logic          mem_we;
    logic [BW-1:0] mem_waddr;
    logic [63:0]   mem_wdata;
    logic [64:0]   sum_full;
    logic [63:0]   sum;
    logic          sat;

    assign sum_full = 65'(rdata_reg) + 65'(inc_reg);
    assign sat      = sum_full[64];
    assign sum      = sat ? '1 : sum_full[63:0];

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        if (cmd.clr_en) begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
        end else if (cmd.upd_en) begin
            if (req_reg == REQ_ADD) begin
                mem_we    = !drop_reg;
                mem_wdata = sum;
            end else if (req_reg == REQ_READ_CLEAR) begin
                mem_we    = ridx_ok;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) bin_mem[mem_waddr] <= mem_wdata;
        if (cmd.rd_en) rdata_reg <= bin_mem[addr_reg];
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.upd_en) begin
            out_bin     <= '0;
            out_total   <= '0;
            out_dropped <= 1'b0;
            out_under   <= 1'b0;
            out_sat     <= 1'b0;
            unique case (req_reg)
                REQ_ADD: begin
                    if (drop_reg) begin
                        out_dropped <= 1'b1;
                    end else begin
                        out_bin   <= 12'(addr_reg);
                        out_total <= sum;
                        out_under <= under_reg;
                        out_sat   <= sat;
                    end
                end
                REQ_READ, REQ_READ_CLEAR: begin
                    out_bin   <= ridx_reg;
                    out_total <= ridx_ok ? rdata_reg : '0;
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/weighted_histogram_binner_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Requests are taken one at a time; s_tready is low until the update of the last one,
// which waits while an untaken result is held. Each request walks the controller through
// leading-one search, key, multiply, bin select, store read and update in turn.
// Reset (aresetn low, synchronous) restores the configuration registers to their defaults and then
// runs a clearing pass over every bin of the bin store before s_tready rises.

module weighted_histogram_binner_core
    import whb_pkg::*;
#(
    parameter int NUM_BINS       = 4096,
    parameter int LOG_TABLE_BITS = 8
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // Request channel
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // sample_value[31:0], sample_weight[63:32], volume[95:64],
    // read_index[107:96], zero padding [111:108]
    input  wire logic [111:0] s_tdata,
    // req_type[1:0]
    input  wire logic [1:0]   s_tuser,
    // Result channel
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // bin_number[11:0], bin_total[75:12], zero padding [79:76]
    output logic [79:0]       m_tdata,
    // sample_dropped[0], sample_underflow[1], total_saturated[2]
    output logic [2:0]        m_tuser,
    // Configuration write channel; always ready
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);

    whb_cmd_t    cmd;
    whb_status_t status;

    logic [11:0] out_bin;
    logic [63:0] out_total;
    logic        out_dropped, out_under, out_sat;

    // Registers may be written at any time; the user writes them only while idle.
    assign cfg_ready = 1'b1;

    // The controller sequences one request at a time; the result register in the
    // datapath holds a finished beat while the next request is already accepted.
    whb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    whb_dpath #(
        .NUM_BINS       (NUM_BINS),
        .LOG_TABLE_BITS (LOG_TABLE_BITS)
    ) u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .cfg_valid   (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_req      (s_tuser),
        .in_x        (s_tdata[31:0]),
        .in_w        (s_tdata[63:32]),
        .in_v        (s_tdata[95:64]),
        .in_ridx     (s_tdata[107:96]),
        .out_bin     (out_bin),
        .out_total   (out_total),
        .out_dropped (out_dropped),
        .out_under   (out_under),
        .out_sat     (out_sat)
    );

    assign m_tdata = {4'd0, out_total, out_bin};
    assign m_tuser = {out_sat, out_under, out_dropped};

endmodule

`default_nettype wire
